// File: rtl/wphc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wphc_pkg;

   // field and register widths
   localparam int TARGET_W     = 7;
   localparam int DIMS_W       = 3;
   localparam int RADIUS_W     = 23;
   localparam int GAIN_W       = 16;
   localparam int CMD_W        = 1;
   localparam int COORD_W      = 16;
   localparam int POS_W        = 24;
   localparam int ANGLE_W      = 16;
   localparam int DRIVE_W      = 24;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 23;

   // waypoint table
   localparam int TABLE_DEPTH  = 256;
   localparam int TABLE_ADDR_W = $clog2(TABLE_DEPTH);
   localparam int ROW_W        = TARGET_W + DIMS_W;

   // datapath widths
   localparam int DELTA_W      = POS_W + 1;
   localparam int MUL_W        = DELTA_W;
   localparam int PROD_W       = 2 * MUL_W;
   localparam int CORDIC_W     = DELTA_W + 3;
   localparam int Z_W          = ANGLE_W + 1;
   localparam int ERR_W        = ANGLE_W + 1;
   localparam int ERR_CALC_W   = ERR_W + 1;

   // cordic iteration count
   localparam int CORDIC_ITERATIONS = 16;
   localparam int ITER_W            = $clog2(CORDIC_ITERATIONS);
   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERATIONS - 1);

   // angle constants in q3.13
   localparam logic signed [ANGLE_W-1:0]    PI_Q13       = 16'sd25736;
   localparam logic signed [ANGLE_W-1:0]    NEG_PI_Q13   = -16'sd25736;
   localparam logic signed [ERR_CALC_W-1:0] PI_WIDE      = 18'sd25736;
   localparam logic signed [ERR_CALC_W-1:0] NEG_PI_WIDE  = -18'sd25736;
   localparam logic signed [ERR_CALC_W-1:0] TWO_PI_WIDE  = 18'sd51472;

   // drive limits and rounding
   localparam logic signed [PROD_W-1:0] DRIVE_MAX_WIDE = 50'sd8388607;
   localparam logic signed [PROD_W-1:0] DRIVE_MIN_WIDE = -50'sd8388608;
   localparam logic signed [PROD_W-1:0] DRIVE_ROUND    = 50'sd128;
   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX     = 24'sd8388607;
   localparam logic signed [DRIVE_W-1:0] DRIVE_MIN     = -24'sd8388608;

   // request commands
   localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
   localparam logic [CMD_W-1:0] CMD_POSE = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYPOINT_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATE_DIMS     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUCCESS_RADIUS = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADING_GAIN   = 2'd3;

   // register reset values
   localparam logic [TARGET_W-1:0] COUNT_RESET  = 7'd0;
   localparam logic [DIMS_W-1:0]   DIMS_RESET   = 3'd2;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd256;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd2560;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ADDR_X,
      ST_ADDR_Y,
      ST_DATA_Y,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_R,
      ST_COMPARE,
      ST_RECHECK,
      ST_CORDIC_INIT,
      ST_CORDIC,
      ST_SATURATE,
      ST_ERROR,
      ST_GAIN,
      ST_DRIVE,
      ST_OUTPUT
   } state_type;

   // arctangent of 2^-i in q3.13
   function automatic logic signed [Z_W-1:0] atan_q13(input logic [ITER_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      case (idx)
         4'd0:    val = 17'sd6434;
         4'd1:    val = 17'sd3798;
         4'd2:    val = 17'sd2007;
         4'd3:    val = 17'sd1019;
         4'd4:    val = 17'sd511;
         4'd5:    val = 17'sd256;
         4'd6:    val = 17'sd128;
         4'd7:    val = 17'sd64;
         4'd8:    val = 17'sd32;
         4'd9:    val = 17'sd16;
         4'd10:   val = 17'sd8;
         4'd11:   val = 17'sd4;
         4'd12:   val = 17'sd2;
         4'd13:   val = 17'sd1;
         default: val = 17'sd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// File: rtl/wphc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module wphc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/waypoint_heading_p_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Waypoint-following heading controller. A load request (cmd 0) writes one
// signed integer coordinate into the 256-entry waypoint table and gives no
// response; waypoint k keeps x at entry k*state_dims and y at entry
// k*state_dims+1, and entries never written read as garbage. A pose
// request (cmd 1) gives exactly one response: it advances the target when
// the squared distance is below the squared success radius, then reports
// done with zero drive once the path is finished, or else the bearing to the
// target (Q3.13) and drive = gain * wrapped heading error (Q11.13). The
// vectoring CORDIC runs one iteration per cycle on a single shift-and-add
// unit, and the squares and the gain product take turns on one 25x25
// multiplier. Requests are stalled while a pose request is in progress; a
// finished response waits in an output register while the next request is
// taken.
module waypoint_heading_p_controller (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [wphc_pkg::CMD_W-1:0]            req_cmd,
   input  wire logic [wphc_pkg::TABLE_ADDR_W-1:0]     req_entry_index,
   input  wire logic signed [wphc_pkg::COORD_W-1:0]   req_entry_value,
   input  wire logic signed [wphc_pkg::POS_W-1:0]     req_pos_x,
   input  wire logic signed [wphc_pkg::POS_W-1:0]     req_pos_y,
   input  wire logic signed [wphc_pkg::ANGLE_W-1:0]   req_heading,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [wphc_pkg::DRIVE_W-1:0]        rsp_drive,
   output logic signed [wphc_pkg::ANGLE_W-1:0]        rsp_desired_heading,
   output logic [wphc_pkg::TARGET_W-1:0]              rsp_target_index,
   output logic                                       rsp_reached,
   output logic                                       rsp_done_res,
   // configuration
   input  wire logic                                  csr_write_enable,
   input  wire logic [wphc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [wphc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // control registers
   wphc_pkg::state_type state_ff, state_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [wphc_pkg::TARGET_W-1:0]          target_ff, target_in;
   logic [wphc_pkg::TARGET_W-1:0]          count_ff;
   logic [wphc_pkg::DIMS_W-1:0]            dims_ff;
   logic [wphc_pkg::RADIUS_W-1:0]          radius_ff;
   logic [wphc_pkg::GAIN_W-1:0]            gain_ff;

   // working registers
   logic signed [wphc_pkg::POS_W-1:0]      px_ff, px_in;
   logic signed [wphc_pkg::POS_W-1:0]      py_ff, py_in;
   logic signed [wphc_pkg::ANGLE_W-1:0]    heading_ff, heading_in;
   logic signed [wphc_pkg::DELTA_W-1:0]    dx_ff, dx_in;
   logic signed [wphc_pkg::DELTA_W-1:0]    dy_ff, dy_in;
   logic signed [wphc_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic signed [wphc_pkg::PROD_W-1:0]     acc_ff, acc_in;
   logic signed [wphc_pkg::CORDIC_W-1:0]   x_ff, x_in;
   logic signed [wphc_pkg::CORDIC_W-1:0]   y_ff, y_in;
   logic signed [wphc_pkg::Z_W-1:0]        z_ff, z_in;
   logic signed [wphc_pkg::ANGLE_W-1:0]    base_ff, base_in;
   logic [wphc_pkg::ITER_W-1:0]            iter_ff, iter_in;
   logic signed [wphc_pkg::ANGLE_W-1:0]    desired_ff, desired_in;
   logic signed [wphc_pkg::ERR_W-1:0]      err_ff, err_in;
   logic signed [wphc_pkg::DRIVE_W-1:0]    drive_ff, drive_in;
   logic                                   reached_ff, reached_in;
   logic                                   done_ff, done_in;
   logic                                   pass2_ff, pass2_in;

   // response registers
   logic signed [wphc_pkg::DRIVE_W-1:0]    rsp_drive_ff, rsp_drive_in;
   logic signed [wphc_pkg::ANGLE_W-1:0]    rsp_desired_ff, rsp_desired_in;
   logic [wphc_pkg::TARGET_W-1:0]          rsp_target_ff, rsp_target_in;
   logic                                   rsp_reached_ff, rsp_reached_in;
   logic                                   rsp_done_ff, rsp_done_in;

   // combinational helpers
   logic                                   idle;
   logic                                   req_accept;
   logic                                   load_accept;
   logic                                   pose_accept;
   logic                                   done_now;
   logic                                   out_free;
   logic [wphc_pkg::ROW_W-1:0]             row_base;
   logic [wphc_pkg::TABLE_ADDR_W-1:0]      ram_raddr;
   logic [wphc_pkg::COORD_W-1:0]           ram_rdata;
   logic signed [wphc_pkg::DELTA_W-1:0]    coord_pos;
   logic signed [wphc_pkg::DELTA_W-1:0]    pos_sel;
   logic signed [wphc_pkg::DELTA_W-1:0]    delta;
   logic signed [wphc_pkg::MUL_W-1:0]      mul_a;
   logic signed [wphc_pkg::MUL_W-1:0]      mul_b;
   logic signed [wphc_pkg::PROD_W-1:0]     mul_p;
   logic signed [wphc_pkg::CORDIC_W-1:0]   x_shift;
   logic signed [wphc_pkg::CORDIC_W-1:0]   y_shift;
   logic signed [wphc_pkg::Z_W-1:0]        atan_step;
   logic signed [wphc_pkg::Z_W:0]          z_sum;
   logic signed [wphc_pkg::ERR_CALC_W-1:0] err_raw;
   logic signed [wphc_pkg::PROD_W-1:0]     drive_wide;

   // handshake
   assign idle        = (state_ff == wphc_pkg::ST_IDLE);
   assign req_stall   = !idle;
   assign req_accept  = req_valid && idle;
   assign load_accept = req_accept && (req_cmd == wphc_pkg::CMD_LOAD);
   assign pose_accept = req_accept && (req_cmd == wphc_pkg::CMD_POSE);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign done_now    = (target_ff >= count_ff);

   // waypoint table address: row start plus dimension, wrapping at the table size
   assign row_base  = wphc_pkg::ROW_W'(target_ff) * wphc_pkg::ROW_W'(dims_ff);
   assign ram_raddr = row_base[wphc_pkg::TABLE_ADDR_W-1:0]
                    + wphc_pkg::TABLE_ADDR_W'(state_ff == wphc_pkg::ST_ADDR_Y);

   wphc_ram #(
      .WIDTH (wphc_pkg::COORD_W),
      .DEPTH (wphc_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_accept),
      .wr_addr (req_entry_index),
      .wr_data (req_entry_value),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // coordinate scaled to q16.8 minus position
   assign coord_pos = {ram_rdata[wphc_pkg::COORD_W-1], ram_rdata, 8'b0};
   assign pos_sel   = (state_ff == wphc_pkg::ST_DATA_Y) ? {py_ff[wphc_pkg::POS_W-1], py_ff}
                                                       : {px_ff[wphc_pkg::POS_W-1], px_ff};
   assign delta     = coord_pos - pos_sel;

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         wphc_pkg::ST_SQ_X: begin
            mul_a = dx_ff;
            mul_b = dx_ff;
         end
         wphc_pkg::ST_SQ_Y: begin
            mul_a = dy_ff;
            mul_b = dy_ff;
         end
         wphc_pkg::ST_SQ_R: begin
            mul_a = signed'(wphc_pkg::MUL_W'(radius_ff));
            mul_b = signed'(wphc_pkg::MUL_W'(radius_ff));
         end
         wphc_pkg::ST_GAIN: begin
            mul_a = signed'(wphc_pkg::MUL_W'(gain_ff));
            mul_b = wphc_pkg::MUL_W'(err_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // cordic step terms
   assign x_shift   = x_ff >>> iter_ff;
   assign y_shift   = y_ff >>> iter_ff;
   assign atan_step = wphc_pkg::atan_q13(iter_ff);
   assign z_sum     = (wphc_pkg::Z_W + 1)'(z_ff) + (wphc_pkg::Z_W + 1)'(base_ff);

   // heading error before wrap
   assign err_raw = wphc_pkg::ERR_CALC_W'(desired_ff) - wphc_pkg::ERR_CALC_W'(heading_ff);

   // rounded gain product
   assign drive_wide = (prod_ff + wphc_pkg::DRIVE_ROUND) >>> 8;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wphc_pkg::ST_IDLE: begin
            if (pose_accept) state_in = wphc_pkg::ST_CHECK;
         end
         wphc_pkg::ST_CHECK: begin
            state_in = done_now ? wphc_pkg::ST_OUTPUT : wphc_pkg::ST_ADDR_X;
         end
         wphc_pkg::ST_ADDR_X:  state_in = wphc_pkg::ST_ADDR_Y;
         wphc_pkg::ST_ADDR_Y:  state_in = wphc_pkg::ST_DATA_Y;
         wphc_pkg::ST_DATA_Y: begin
            state_in = pass2_ff ? wphc_pkg::ST_CORDIC_INIT : wphc_pkg::ST_SQ_X;
         end
         wphc_pkg::ST_SQ_X:    state_in = wphc_pkg::ST_SQ_Y;
         wphc_pkg::ST_SQ_Y:    state_in = wphc_pkg::ST_SQ_R;
         wphc_pkg::ST_SQ_R:    state_in = wphc_pkg::ST_COMPARE;
         wphc_pkg::ST_COMPARE: state_in = wphc_pkg::ST_RECHECK;
         wphc_pkg::ST_RECHECK: begin
            priority if (done_now) state_in = wphc_pkg::ST_OUTPUT;
            else if (reached_ff)   state_in = wphc_pkg::ST_ADDR_X;
            else                   state_in = wphc_pkg::ST_CORDIC_INIT;
         end
         wphc_pkg::ST_CORDIC_INIT: begin
            state_in = (dy_ff == '0) ? wphc_pkg::ST_ERROR : wphc_pkg::ST_CORDIC;
         end
         wphc_pkg::ST_CORDIC: begin
            if (iter_ff == wphc_pkg::ITER_LAST) state_in = wphc_pkg::ST_SATURATE;
         end
         wphc_pkg::ST_SATURATE: state_in = wphc_pkg::ST_ERROR;
         wphc_pkg::ST_ERROR:    state_in = wphc_pkg::ST_GAIN;
         wphc_pkg::ST_GAIN:     state_in = wphc_pkg::ST_DRIVE;
         wphc_pkg::ST_DRIVE:    state_in = wphc_pkg::ST_OUTPUT;
         wphc_pkg::ST_OUTPUT: begin
            if (out_free) state_in = wphc_pkg::ST_IDLE;
         end
         default: state_in = wphc_pkg::ST_IDLE;
      endcase
   end

   // datapath and response updates
   always_comb begin
      px_in          = px_ff;
      py_in          = py_ff;
      heading_in     = heading_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      prod_in        = mul_p;
      acc_in         = acc_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      base_in        = base_ff;
      iter_in        = iter_ff;
      desired_in     = desired_ff;
      err_in         = err_ff;
      drive_in       = drive_ff;
      reached_in     = reached_ff;
      done_in        = done_ff;
      pass2_in       = pass2_ff;
      target_in      = target_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_drive_in   = rsp_drive_ff;
      rsp_desired_in = rsp_desired_ff;
      rsp_target_in  = rsp_target_ff;
      rsp_reached_in = rsp_reached_ff;
      rsp_done_in    = rsp_done_ff;

      unique case (state_ff)
         // capture pose request
         wphc_pkg::ST_IDLE: begin
            if (pose_accept) begin
               px_in      = req_pos_x;
               py_in      = req_pos_y;
               heading_in = req_heading;
               reached_in = 1'b0;
               done_in    = 1'b0;
               pass2_in   = 1'b0;
               desired_in = '0;
               drive_in   = '0;
            end
         end
         wphc_pkg::ST_CHECK: begin
            if (done_now) done_in = 1'b1;
         end
         wphc_pkg::ST_ADDR_X: begin
         end
         wphc_pkg::ST_ADDR_Y: dx_in = delta;
         wphc_pkg::ST_DATA_Y: dy_in = delta;
         wphc_pkg::ST_SQ_X: begin
         end
         wphc_pkg::ST_SQ_Y: acc_in = prod_ff;
         wphc_pkg::ST_SQ_R: acc_in = acc_ff + prod_ff;
         // arrival test against squared radius
         wphc_pkg::ST_COMPARE: begin
            if (acc_ff < prod_ff) begin
               target_in  = target_ff + 1'b1;
               reached_in = 1'b1;
            end
         end
         wphc_pkg::ST_RECHECK: begin
            priority if (done_now) done_in = 1'b1;
            else if (reached_ff)   pass2_in = 1'b1;
            else                   pass2_in = pass2_ff;
         end
         // axis-aligned bearing or cordic start with half-plane fold
         wphc_pkg::ST_CORDIC_INIT: begin
            if (dy_ff == '0) begin
               desired_in = dx_ff[wphc_pkg::DELTA_W-1] ? wphc_pkg::PI_Q13 : '0;
            end else begin
               iter_in = '0;
               z_in    = '0;
               if (dx_ff[wphc_pkg::DELTA_W-1]) begin
                  x_in    = -wphc_pkg::CORDIC_W'(dx_ff);
                  y_in    = -wphc_pkg::CORDIC_W'(dy_ff);
                  base_in = dy_ff[wphc_pkg::DELTA_W-1] ? wphc_pkg::NEG_PI_Q13
                                                       : wphc_pkg::PI_Q13;
               end else begin
                  x_in    = wphc_pkg::CORDIC_W'(dx_ff);
                  y_in    = wphc_pkg::CORDIC_W'(dy_ff);
                  base_in = '0;
               end
            end
         end
         // one vectoring iteration
         wphc_pkg::ST_CORDIC: begin
            if (!y_ff[wphc_pkg::CORDIC_W-1]) begin
               x_in = x_ff + y_shift;
               y_in = y_ff - x_shift;
               z_in = z_ff + atan_step;
            end else begin
               x_in = x_ff - y_shift;
               y_in = y_ff + x_shift;
               z_in = z_ff - atan_step;
            end
            iter_in = iter_ff + 1'b1;
         end
         // clamp bearing to +-pi
         wphc_pkg::ST_SATURATE: begin
            priority if (z_sum > (wphc_pkg::Z_W + 1)'(wphc_pkg::PI_Q13))
               desired_in = wphc_pkg::PI_Q13;
            else if (z_sum < (wphc_pkg::Z_W + 1)'(wphc_pkg::NEG_PI_Q13))
               desired_in = wphc_pkg::NEG_PI_Q13;
            else
               desired_in = wphc_pkg::ANGLE_W'(z_sum);
         end
         // single-pass wrap of heading error
         wphc_pkg::ST_ERROR: begin
            priority if (err_raw > wphc_pkg::PI_WIDE)
               err_in = wphc_pkg::ERR_W'(err_raw - wphc_pkg::TWO_PI_WIDE);
            else if (err_raw < wphc_pkg::NEG_PI_WIDE)
               err_in = wphc_pkg::ERR_W'(err_raw + wphc_pkg::TWO_PI_WIDE);
            else
               err_in = wphc_pkg::ERR_W'(err_raw);
         end
         wphc_pkg::ST_GAIN: begin
         end
         // round and saturate drive
         wphc_pkg::ST_DRIVE: begin
            priority if (drive_wide > wphc_pkg::DRIVE_MAX_WIDE) drive_in = wphc_pkg::DRIVE_MAX;
            else if (drive_wide < wphc_pkg::DRIVE_MIN_WIDE)     drive_in = wphc_pkg::DRIVE_MIN;
            else drive_in = wphc_pkg::DRIVE_W'(drive_wide);
         end
         // hand result to output register
         wphc_pkg::ST_OUTPUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_drive_in   = drive_ff;
               rsp_desired_in = desired_ff;
               rsp_target_in  = target_ff;
               rsp_reached_in = reached_ff;
               rsp_done_in    = done_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wphc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         target_ff    <= '0;
         count_ff     <= wphc_pkg::COUNT_RESET;
         dims_ff      <= wphc_pkg::DIMS_RESET;
         radius_ff    <= wphc_pkg::RADIUS_RESET;
         gain_ff      <= wphc_pkg::GAIN_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         target_ff    <= target_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               wphc_pkg::CSR_WAYPOINT_COUNT: count_ff  <= csr_wdata[wphc_pkg::TARGET_W-1:0];
               wphc_pkg::CSR_STATE_DIMS:     dims_ff   <= csr_wdata[wphc_pkg::DIMS_W-1:0];
               wphc_pkg::CSR_SUCCESS_RADIUS: radius_ff <= csr_wdata[wphc_pkg::RADIUS_W-1:0];
               wphc_pkg::CSR_HEADING_GAIN:   gain_ff   <= csr_wdata[wphc_pkg::GAIN_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      px_ff          <= px_in;
      py_ff          <= py_in;
      heading_ff     <= heading_in;
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      z_ff           <= z_in;
      base_ff        <= base_in;
      iter_ff        <= iter_in;
      desired_ff     <= desired_in;
      err_ff         <= err_in;
      drive_ff       <= drive_in;
      reached_ff     <= reached_in;
      done_ff        <= done_in;
      pass2_ff       <= pass2_in;
      rsp_drive_ff   <= rsp_drive_in;
      rsp_desired_ff <= rsp_desired_in;
      rsp_target_ff  <= rsp_target_in;
      rsp_reached_ff <= rsp_reached_in;
      rsp_done_ff    <= rsp_done_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive           = rsp_drive_ff;
   assign rsp_desired_heading = rsp_desired_ff;
   assign rsp_target_index    = rsp_target_ff;
   assign rsp_reached         = rsp_reached_ff;
   assign rsp_done_res        = rsp_done_ff;

endmodule

`default_nettype wire

// File: rtl/wphc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wphc_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   input  wire logic signed [wphc_pkg::DRIVE_W-1:0]   rsp_drive,
   input  wire logic signed [wphc_pkg::ANGLE_W-1:0]   rsp_desired_heading,
   input  wire logic [wphc_pkg::TARGET_W-1:0]         rsp_target_index,
   input  wire logic                                  rsp_reached,
   input  wire logic                                  rsp_done_res
);

   // no response survives reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // finished path gives zero drive and zero bearing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_drive == '0 && rsp_desired_heading == '0)
      else $error("done response with nonzero drive or bearing");

   // bearing stays within +-pi
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_desired_heading <= wphc_pkg::PI_Q13
                 && rsp_desired_heading >= wphc_pkg::NEG_PI_Q13)
      else $error("bearing outside +-pi");

   // an advance never lands on the first waypoint
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reached |-> rsp_target_index != '0)
      else $error("advance reported with target index zero");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive)
                              && $stable(rsp_target_index))
      else $error("stalled response changed");

endmodule

bind waypoint_heading_p_controller wphc_checker u_checker (.*);

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int     SETTLE_CYCLES  = 40;
   localparam int     RANDOM_PHASES  = 9;
   localparam int     PHASE_REQUESTS = 40;
   localparam int     FINAL_REQUESTS = 60;
   localparam longint POS_HI         = 8388607;
   localparam longint POS_LO         = -8388608;
   localparam longint HALF_TURN      = 25736;
   localparam longint FULL_TURN      = 51472;
   localparam longint DRIVE_HI       = 8388607;
   localparam longint DRIVE_LO       = -8388608;
   localparam longint ATAN_STEP [0:15] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64,
                                           32, 16, 8, 4, 2, 1, 0, 0};

   typedef struct {
      logic [wphc_pkg::CMD_W-1:0]            cmd;
      logic [wphc_pkg::TABLE_ADDR_W-1:0]     index;
      logic signed [wphc_pkg::COORD_W-1:0]   value;
      logic signed [wphc_pkg::POS_W-1:0]     pos_x;
      logic signed [wphc_pkg::POS_W-1:0]     pos_y;
      logic signed [wphc_pkg::ANGLE_W-1:0]   heading;
   } steer_req_type;

   typedef struct {
      logic signed [wphc_pkg::DRIVE_W-1:0]   drive;
      logic signed [wphc_pkg::ANGLE_W-1:0]   bearing;
      logic [wphc_pkg::TARGET_W-1:0]         target;
      logic                                  reached;
      logic                                  done;
   } steer_rsp_type;

   // clock, reset and block ports
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic [wphc_pkg::CMD_W-1:0]            req_cmd = wphc_pkg::CMD_LOAD;
   logic [wphc_pkg::TABLE_ADDR_W-1:0]     req_entry_index = '0;
   logic signed [wphc_pkg::COORD_W-1:0]   req_entry_value = '0;
   logic signed [wphc_pkg::POS_W-1:0]     req_pos_x = '0;
   logic signed [wphc_pkg::POS_W-1:0]     req_pos_y = '0;
   logic signed [wphc_pkg::ANGLE_W-1:0]   req_heading = '0;

   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic signed [wphc_pkg::DRIVE_W-1:0]   rsp_drive;
   logic signed [wphc_pkg::ANGLE_W-1:0]   rsp_desired_heading;
   logic [wphc_pkg::TARGET_W-1:0]         rsp_target_index;
   logic                                  rsp_reached;
   logic                                  rsp_done_res;

   logic                                  csr_write_enable = 1'b0;
   logic [wphc_pkg::CSR_INDEX_W-1:0]      csr_index = wphc_pkg::CSR_WAYPOINT_COUNT;
   logic [wphc_pkg::CSR_DATA_W-1:0]       csr_wdata = '0;

   // predictor state and configuration
   logic signed [wphc_pkg::COORD_W-1:0]   wp_table [wphc_pkg::TABLE_DEPTH];
   logic [wphc_pkg::TARGET_W-1:0]         cur_target = wphc_pkg::COUNT_RESET;
   logic [wphc_pkg::TARGET_W-1:0]         path_len = wphc_pkg::COUNT_RESET;
   logic [wphc_pkg::DIMS_W-1:0]           row_stride = wphc_pkg::DIMS_RESET;
   logic [wphc_pkg::RADIUS_W-1:0]         arrive_radius = wphc_pkg::RADIUS_RESET;
   logic [wphc_pkg::GAIN_W-1:0]           steer_gain = wphc_pkg::GAIN_RESET;

   // stimulus side copy of the table contents, in request order
   logic signed [wphc_pkg::COORD_W-1:0]   plan_table [wphc_pkg::TABLE_DEPTH];

   steer_req_type req_backlog[$];
   steer_rsp_type owed_steering[$];
   steer_req_type on_wire;
   steer_rsp_type want;

   int  queued_count = 0;
   int  accepted_count = 0;
   int  load_count = 0;
   int  pose_count = 0;
   int  setting_count = 0;
   int  checked_count = 0;
   int  arrival_count = 0;
   int  done_count = 0;
   int  mismatches = 0;
   int  send_hold = 0;
   int  rsp_hold = 0;
   bit  send_calm = 1'b0;
   bit  recv_calm = 1'b0;

   waypoint_heading_p_controller uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_entry_index     (req_entry_index),
      .req_entry_value     (req_entry_value),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_heading         (req_heading),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_drive           (rsp_drive),
      .rsp_desired_heading (rsp_desired_heading),
      .rsp_target_index    (rsp_target_index),
      .rsp_reached         (rsp_reached),
      .rsp_done_res        (rsp_done_res),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // flat table address of one coordinate of waypoint k
   function automatic logic [wphc_pkg::TABLE_ADDR_W-1:0] row_addr(int k, int dim);
      return wphc_pkg::TABLE_ADDR_W'(k * int'(row_stride) + dim);
   endfunction

   function automatic longint target_coord(int dim);
      return longint'(wp_table[row_addr(int'(cur_target), dim)]) * 256;
   endfunction

   // vectoring cordic bearing, q3.13, with the dy == 0 cases handled up front
   function automatic longint bearing_of(longint dx, longint dy);
      longint x, y, z, base, xs, ys;
      x = dx;
      y = dy;
      z = 0;
      base = 0;
      if (dy == 0) begin
         return (dx < 0) ? HALF_TURN : 0;
      end
      if (dx < 0) begin
         x = -dx;
         y = -dy;
         base = (dy > 0) ? HALF_TURN : -HALF_TURN;
      end
      for (int i = 0; i < wphc_pkg::CORDIC_ITERATIONS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_STEP[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_STEP[i];
         end
      end
      z = z + base;
      if (z > HALF_TURN) z = HALF_TURN;
      if (z < -HALF_TURN) z = -HALF_TURN;
      return z;
   endfunction

   // one pose sample: arrival test, then bearing and steering drive
   function automatic steer_rsp_type follow_pose(steer_req_type rq);
      steer_rsp_type r;
      longint dx, dy, d2, r2, err, drv;
      r.drive = '0;
      r.bearing = '0;
      r.reached = 1'b0;
      r.done = 1'b0;
      if (cur_target < path_len) begin
         dx = target_coord(0) - longint'(rq.pos_x);
         dy = target_coord(1) - longint'(rq.pos_y);
         d2 = dx * dx + dy * dy;
         r2 = longint'(arrive_radius) * longint'(arrive_radius);
         if (d2 < r2) begin
            cur_target = cur_target + 1'b1;
            r.reached = 1'b1;
         end
      end
      if (cur_target >= path_len) begin
         r.done = 1'b1;
      end else begin
         dx = target_coord(0) - longint'(rq.pos_x);
         dy = target_coord(1) - longint'(rq.pos_y);
         err = bearing_of(dx, dy);
         r.bearing = wphc_pkg::ANGLE_W'(err);
         err = err - longint'(rq.heading);
         if (err > HALF_TURN) err = err - FULL_TURN;
         if (err < -HALF_TURN) err = err + FULL_TURN;
         drv = (longint'(steer_gain) * err + 128) >>> 8;
         if (drv > DRIVE_HI) drv = DRIVE_HI;
         if (drv < DRIVE_LO) drv = DRIVE_LO;
         r.drive = wphc_pkg::DRIVE_W'(drv);
      end
      r.target = cur_target;
      return r;
   endfunction

   function automatic void take_request(steer_req_type rq);
      if (rq.cmd == wphc_pkg::CMD_LOAD) begin
         wp_table[rq.index] = rq.value;
         load_count++;
      end else begin
         owed_steering.push_back(follow_pose(rq));
         pose_count++;
      end
   endfunction

   function automatic int draw_wait(bit calm);
      if (calm) return 0;
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_hold = 0;
      end else begin
         if (req_valid && !req_stall) begin
            take_request(on_wire);
            accepted_count++;
            send_hold = draw_wait(send_calm);
         end
         if (!(req_valid && req_stall)) begin
            if (send_hold > 0) begin
               send_hold--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               on_wire = req_backlog.pop_front();
               req_cmd <= on_wire.cmd;
               req_entry_index <= on_wire.index;
               req_entry_value <= on_wire.value;
               req_pos_x <= on_wire.pos_x;
               req_pos_y <= on_wire.pos_y;
               req_heading <= on_wire.heading;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_steering.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = owed_steering.pop_front();
               checked_count++;
               if (want.reached) arrival_count++;
               if (want.done) done_count++;
               if (rsp_drive !== want.drive) begin
                  $error("drive: expected %0d, got %0d", want.drive, rsp_drive);
                  mismatches++;
               end
               if (rsp_desired_heading !== want.bearing) begin
                  $error("desired_heading: expected %0d, got %0d",
                         want.bearing, rsp_desired_heading);
                  mismatches++;
               end
               if (rsp_target_index !== want.target) begin
                  $error("target_index: expected %0d, got %0d",
                         want.target, rsp_target_index);
                  mismatches++;
               end
               if (rsp_reached !== want.reached) begin
                  $error("reached: expected %0d, got %0d", want.reached, rsp_reached);
                  mismatches++;
               end
               if (rsp_done_res !== want.done) begin
                  $error("done_res: expected %0d, got %0d", want.done, rsp_done_res);
                  mismatches++;
               end
            end
            rsp_hold = draw_wait(recv_calm);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold > 0);
      end
   end

   // stimulus helpers
   function automatic longint rand_span(longint s);
      return longint'($urandom_range(0, 32'(2 * s))) - s;
   endfunction

   function automatic logic signed [wphc_pkg::POS_W-1:0] clamp_pos(longint v);
      if (v > POS_HI) v = POS_HI;
      if (v < POS_LO) v = POS_LO;
      return wphc_pkg::POS_W'(v);
   endfunction

   function automatic logic signed [wphc_pkg::ANGLE_W-1:0] rand_heading();
      return wphc_pkg::ANGLE_W'(int'($urandom_range(0, 51472)) - 25736);
   endfunction

   function automatic logic signed [wphc_pkg::COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 7))
         0:       return -16'sd32768;
         1:       return 16'sd32767;
         default: return wphc_pkg::COORD_W'($urandom);
      endcase
   endfunction

   function automatic longint plan_coord(int k, int dim);
      return longint'(plan_table[row_addr(k, dim)]) * 256;
   endfunction

   task automatic push_load(logic [wphc_pkg::TABLE_ADDR_W-1:0] idx,
                            logic signed [wphc_pkg::COORD_W-1:0] val);
      steer_req_type rq;
      rq.cmd = wphc_pkg::CMD_LOAD;
      rq.index = idx;
      rq.value = val;
      rq.pos_x = wphc_pkg::POS_W'($urandom);
      rq.pos_y = wphc_pkg::POS_W'($urandom);
      rq.heading = rand_heading();
      plan_table[idx] = val;
      req_backlog.push_back(rq);
      queued_count++;
   endtask

   task automatic push_pose(logic signed [wphc_pkg::POS_W-1:0] px,
                            logic signed [wphc_pkg::POS_W-1:0] py,
                            logic signed [wphc_pkg::ANGLE_W-1:0] hdg);
      steer_req_type rq;
      rq.cmd = wphc_pkg::CMD_POSE;
      rq.index = wphc_pkg::TABLE_ADDR_W'($urandom);
      rq.value = wphc_pkg::COORD_W'($urandom);
      rq.pos_x = px;
      rq.pos_y = py;
      rq.heading = hdg;
      req_backlog.push_back(rq);
      queued_count++;
   endtask

   // pose inside the arrival circle of waypoint k
   task automatic push_arrival(int k);
      longint reach;
      reach = longint'(arrive_radius) / 2;
      push_pose(clamp_pos(plan_coord(k, 0) + rand_span(reach)),
                clamp_pos(plan_coord(k, 1) + rand_span(reach)), rand_heading());
   endtask

   // pose somewhere around waypoint k, optionally level with it
   task automatic push_near(int k, bit level);
      longint bx, by, span;
      bx = 0;
      by = 0;
      span = 4 * longint'(arrive_radius) + 1000;
      if (k < path_len) begin
         bx = plan_coord(k, 0);
         by = plan_coord(k, 1);
      end
      push_pose(clamp_pos(bx + rand_span(span)),
                level ? clamp_pos(by) : clamp_pos(by + rand_span(span)), rand_heading());
   endtask

   task automatic push_random_pose();
      push_pose(wphc_pkg::POS_W'($urandom), wphc_pkg::POS_W'($urandom), rand_heading());
   endtask

   // write table entries for waypoints first .. last-1
   task automatic load_path(int first, int last);
      for (int k = first; k < last; k++) begin
         for (int d = 0; d < 2; d++) begin
            push_load(row_addr(k, d), rand_coord());
         end
      end
   endtask

   // wait until every request is taken and answered, then let the block go quiet
   task automatic settle();
      do @(posedge clock);
      while (accepted_count != queued_count || owed_steering.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [wphc_pkg::CSR_INDEX_W-1:0] idx, longint val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wphc_pkg::CSR_DATA_W'(val);
      case (idx)
         wphc_pkg::CSR_WAYPOINT_COUNT: path_len = wphc_pkg::TARGET_W'(val);
         wphc_pkg::CSR_STATE_DIMS:     row_stride = wphc_pkg::DIMS_W'(val);
         wphc_pkg::CSR_SUCCESS_RADIUS: arrive_radius = wphc_pkg::RADIUS_W'(val);
         wphc_pkg::CSR_HEADING_GAIN:   steer_gain = wphc_pkg::GAIN_W'(val);
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_write_enable <= 1'b0;
      setting_count++;
      @(negedge clock);
   endtask

   task automatic write_all(longint count, longint dims, longint radius, longint gain);
      write_reg(wphc_pkg::CSR_WAYPOINT_COUNT, count);
      write_reg(wphc_pkg::CSR_STATE_DIMS, dims);
      write_reg(wphc_pkg::CSR_SUCCESS_RADIUS, radius);
      write_reg(wphc_pkg::CSR_HEADING_GAIN, gain);
      end_writes();
   endtask

   // run limit
   initial begin
      #5000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // main sequence
   initial begin
      int t;
      int adv;
      int arrivals_left;
      int aim;
      int pick;
      int stride;
      int radius;
      int gain;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty path after reset: every pose reports done
      push_load(8'd255, 16'sd32767);
      push_load(8'd0, -16'sd32768);
      push_pose(24'sd8388607, -24'sd8388608, 16'sd25736);
      push_pose(-24'sd8388608, 24'sd8388607, -16'sd25736);
      push_pose(24'sd0, 24'sd0, 16'sd0);
      settle();

      // four waypoints with extreme coordinates
      write_all(4, 2, 256, 2560);
      push_load(8'd0, 16'sd10);
      push_load(8'd1, 16'sd0);
      push_load(8'd2, -16'sd32768);
      push_load(8'd3, 16'sd32767);
      push_load(8'd4, 16'sd32767);
      push_load(8'd5, -16'sd32768);
      push_load(8'd6, 16'sd0);
      push_load(8'd7, 16'sd5);
      // target dead ahead, then behind, then straight up
      push_pose(24'sd0, 24'sd0, 16'sd0);
      push_pose(24'sd5120, 24'sd0, 16'sd0);
      push_pose(24'sd2560, -24'sd8388608, 16'sd25736);
      // heading patterns beyond pi, single wrap
      push_pose(-24'sd8388608, 24'sd8388607, 16'sd32767);
      push_pose(24'sd8388607, -24'sd8388608, -16'sd32768);
      // walk the path to its end
      push_pose(24'sd2600, 24'sd50, -16'sd100);
      push_pose(-24'sd8388608, 24'sd8388352, 16'sd1000);
      push_pose(24'sd8388352, -24'sd8388608, 16'sd0);
      push_pose(24'sd0, 24'sd1280, 16'sd0);
      push_pose(24'sd0, 24'sd0, 16'sd0);
      settle();

      // count lowered below the target
      write_reg(wphc_pkg::CSR_WAYPOINT_COUNT, 2);
      end_writes();
      push_random_pose();
      push_random_pose();
      settle();

      // random paths, each extending the previous one by a few waypoints
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         t = int'(cur_target);
         adv = $urandom_range(3, 6);
         stride = (ph == 3) ? 1 : (ph == 6) ? 0 : $urandom_range(2, 4);
         radius = (ph == 2) ? 0 : (ph == 5) ? 1 : $urandom_range(64, 4096);
         gain = (ph == 1) ? 0 : (ph == 4) ? 65535 : $urandom_range(0, 65535);
         send_calm = (ph % 3 == 0);
         recv_calm = (ph % 4 == 1);
         write_all((t + adv > 64) ? 64 : t + adv, stride, radius, gain);
         load_path(t, int'(path_len));
         arrivals_left = ($urandom_range(0, 2) == 0) ? adv : adv - 1;
         aim = t;
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
               push_load(wphc_pkg::TABLE_ADDR_W'($urandom), wphc_pkg::COORD_W'($urandom));
            end else if (pick < 30 && arrivals_left > 0 && aim < path_len) begin
               push_arrival(aim);
               aim++;
               arrivals_left--;
            end else if (pick < 60) begin
               push_near(aim, 1'b0);
            end else if (pick < 70) begin
               push_near(aim, 1'b1);
            end else begin
               push_random_pose();
            end
         end
         settle();
      end

      // full-length path with a wide radius and a stride that wraps the table
      t = int'(cur_target);
      send_calm = 1'b0;
      recv_calm = 1'b0;
      write_all(64, 7, 8388607, $urandom_range(0, 65535));
      load_path(t, 64);
      aim = t;
      for (int n = 0; n < FINAL_REQUESTS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            push_load(wphc_pkg::TABLE_ADDR_W'($urandom), wphc_pkg::COORD_W'($urandom));
         end else if (pick < 55 && aim < path_len) begin
            push_arrival(aim);
            aim++;
         end else begin
            push_random_pose();
         end
      end
      settle();

      $display("sent %0d loads and %0d poses across %0d register settings",
               load_count, pose_count, setting_count);
      $display("checked %0d responses: %0d arrivals, %0d done", checked_count,
               arrival_count, done_count);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
